[sv/rc6_pkg.sv]
// shared constants, types and arithmetic helpers for the rc6 cipher
`default_nettype none

package rc6_pkg;

	localparam int ROUNDS        = 20;
	localparam int RK_COUNT      = 2 * ROUNDS + 4;
	localparam int MAX_KEY_WORDS = 8;
	localparam int KEY_BYTES     = 4 * MAX_KEY_WORDS;
	localparam int KEY_REGS      = KEY_BYTES / 8;
	// key words never outnumber the round keys, so the step count is fixed
	localparam int MIX_STEPS     = 3 * RK_COUNT;

	localparam int ROUND_CNT_W   = $clog2(ROUNDS);
	localparam int MIX_CNT_W     = $clog2(MIX_STEPS);
	localparam int WORDS_W       = $clog2(MAX_KEY_WORDS + 1);
	localparam int KEY_LEN_W     = 6;
	localparam int CFG_INDEX_W   = 3;

	localparam logic [31:0] MAGIC_P = 32'hB7E15163;
	localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_0_7   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_8_15  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_16_23 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_24_31 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN   = 3'd4;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT,
		CELL_FWD2,
		CELL_BACK2
	} cell_op_t;

	typedef enum logic [1:0] {
		MIX_IDLE,
		MIX_LOAD,
		MIX_STEP_A,
		MIX_STEP_B
	} mix_op_t;

	typedef struct packed {
		mix_op_t                    op;
		logic [KEY_LEN_W-1:0]       key_len;
	} mix_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MIXA,
		ST_MIXB,
		ST_PRE,
		ST_ROUND,
		ST_POST,
		ST_DONE
	} state_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [5:0] back;
		back = 6'd32 - {1'b0, n};
		return (x << n) | (x >> back);
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [5:0] back;
		back = 6'd32 - {1'b0, n};
		return (x >> n) | (x << back);
	endfunction

	// x * (2x + 1) mod 2^32, then rotate left by 5
	function automatic logic [31:0] quad_mix(input logic [31:0] x);
		logic [31:0] p;
		p = x * {x[30:0], 1'b1};
		return rotl32(p, 5'd5);
	endfunction

endpackage

`default_nettype wire

[sv/rc6_cell.sv]
// one 32-bit cell of the round-key ring
`default_nettype none

module rc6_cell
	import rc6_pkg::*;
(
	input  wire logic        clk,
	input  wire cell_op_t    op,
	input  wire logic [31:0] init_val,
	input  wire logic [31:0] next1,
	input  wire logic [31:0] next2,
	input  wire logic [31:0] prev2,
	output logic      [31:0] data_q
);

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:  data_q <= data_q;
			CELL_LOAD:  data_q <= init_val;
			CELL_SHIFT: data_q <= next1;
			CELL_FWD2:  data_q <= next2;
			CELL_BACK2: data_q <= prev2;
			default:    data_q <= data_q;
		endcase
	end

endmodule

`default_nettype wire

[sv/rc6_round_unit.sv]
// one rc6 round, encrypt or decrypt, combinational
`default_nettype none

module rc6_round_unit
	import rc6_pkg::*;
(
	input  wire logic        mode,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] c,
	input  wire logic [31:0] d,
	input  wire logic [31:0] k_even,
	input  wire logic [31:0] k_odd,
	output logic      [31:0] a_nx,
	output logic      [31:0] b_nx,
	output logic      [31:0] c_nx,
	output logic      [31:0] d_nx
);

	logic [31:0] src_t;
	logic [31:0] src_u;
	logic [31:0] t;
	logic [31:0] u;

	// decrypt first rotates the words right, so its mix sources are a and c
	assign src_t = (mode == MODE_ENC) ? b : a;
	assign src_u = (mode == MODE_ENC) ? d : c;
	assign t = quad_mix(src_t);
	assign u = quad_mix(src_u);

	always_comb begin
		if (mode == MODE_ENC) begin
			a_nx = b;
			b_nx = rotl32(c ^ u, t[4:0]) + k_odd;
			c_nx = d;
			d_nx = rotl32(a ^ t, u[4:0]) + k_even;
		end else begin
			a_nx = rotr32(d - k_even, u[4:0]) ^ t;
			b_nx = a;
			c_nx = rotr32(b - k_odd, t[4:0]) ^ u;
			d_nx = c;
		end
	end

endmodule

`default_nettype wire

[sv/rc6_key_mix.sv]
// key schedule mixing registers and the ring of key words
`default_nettype none

module rc6_key_mix
	import rc6_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mix_ctl_t    ctl,
	input  wire logic [63:0] key_reg [KEY_REGS],
	input  wire logic [31:0] s_head,
	output logic      [31:0] mix_a_q
);

	logic [31:0]        l_q [MAX_KEY_WORDS];
	logic [31:0]        mix_b_q;
	logic [WORDS_W-1:0] words_q;

	logic [KEY_LEN_W-1:0] len_sat;
	logic [WORDS_W-1:0]   words_nx;
	logic [31:0]          key_word [MAX_KEY_WORDS];
	logic [31:0]          ab_sum;
	logic [31:0]          new_b;

	assign len_sat  = (ctl.key_len > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES)
		: ctl.key_len;
	// empty key still counts as one zero word
	assign words_nx = (len_sat == '0) ? WORDS_W'(1)
		: WORDS_W'((len_sat + KEY_LEN_W'(3)) >> 2);

	always_comb begin
		for (int w = 0; w < MAX_KEY_WORDS; w++) begin
			key_word[w] = '0;
		end
		for (int k = 0; k < KEY_BYTES; k++) begin
			if (KEY_LEN_W'(k) < len_sat) begin
				key_word[k / 4][(k % 4) * 8 +: 8] = key_reg[k / 8][(k % 8) * 8 +: 8];
			end
		end
	end

	assign ab_sum = mix_a_q + mix_b_q;
	assign new_b  = rotl32(l_q[0] + ab_sum, ab_sum[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_a_q <= '0;
			mix_b_q <= '0;
		end else begin
			unique case (ctl.op)
				MIX_LOAD: begin
					mix_a_q <= '0;
					mix_b_q <= '0;
				end
				MIX_STEP_A: mix_a_q <= rotl32(s_head + ab_sum, 5'd3);
				MIX_STEP_B: mix_b_q <= new_b;
				default: ;
			endcase
		end
	end

	// key words rotate through a ring whose length is the word count
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			MIX_LOAD: begin
				words_q <= words_nx;
				for (int w = 0; w < MAX_KEY_WORDS; w++) begin
					l_q[w] <= key_word[w];
				end
			end
			MIX_STEP_B: begin
				for (int w = 0; w < MAX_KEY_WORDS; w++) begin
					l_q[w] <= (WORDS_W'(w) == words_q - WORDS_W'(1)) ? new_b
						: l_q[(w + 1) % MAX_KEY_WORDS];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[sv/rc6_block_cipher.sv]
// rc6-32/20 block cipher top level with key ring and round sequencer
`default_nettype none

// RC6-32/20 block cipher. A block is taken over the in_* transfer with its mode bit
// (0 encrypt, 1 decrypt) and its result appears on out_* after the work is done. The
// block works on one block at a time: from input transfer to result register it runs
// pre-whitening, the 20 rounds through the single round unit, post-whitening and the
// output load. The 44 round keys sit in a ring of cells that rotates two places per
// round, forward to encrypt and backward to decrypt. After any key or key-length
// write the next block first runs the key expansion: a load step, then 132 mixing
// steps that each update the A and then the B mixing register. A new block may be
// taken while the previous result still waits for out_ready.
module rc6_block_cipher
	import rc6_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [63:0]            cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   mode,
	input  wire logic [31:0]            in_word_a,
	input  wire logic [31:0]            in_word_b,
	input  wire logic [31:0]            in_word_c,
	input  wire logic [31:0]            in_word_d,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [31:0]            out_word_a,
	output logic      [31:0]            out_word_b,
	output logic      [31:0]            out_word_c,
	output logic      [31:0]            out_word_d
);

	state_t                 state_q;
	state_t                 state_nx;
	logic                   keys_ready_q;
	logic [ROUND_CNT_W-1:0] round_cnt_q;
	logic [MIX_CNT_W-1:0]   mix_cnt_q;
	logic                   out_valid_q;
	logic [63:0]            key_reg_q [KEY_REGS];
	logic [KEY_LEN_W-1:0]   key_len_q;

	logic        mode_q;
	logic [31:0] wa_q;
	logic [31:0] wb_q;
	logic [31:0] wc_q;
	logic [31:0] wd_q;

	logic [31:0] ring [RK_COUNT];
	logic [31:0] mix_a;
	cell_op_t    cell_op;
	mix_ctl_t    mix_ctl;

	logic [31:0] ra;
	logic [31:0] rb;
	logic [31:0] rc;
	logic [31:0] rd;

	logic in_xfer;
	logic cfg_xfer;
	logic out_load;
	logic mix_last;
	logic round_last;

	assign cfg_ready  = 1'b1;
	assign cfg_xfer   = cfg_valid && cfg_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign mix_last   = (mix_cnt_q == MIX_CNT_W'(MIX_STEPS - 1));
	assign round_last = (round_cnt_q == ROUND_CNT_W'(ROUNDS - 1));

	// round-key ring
	for (genvar g = 0; g < RK_COUNT; g++) begin : g_ring
		localparam logic [31:0] INIT = MAGIC_P + MAGIC_Q * 32'(g);
		logic [31:0] next1;
		assign next1 = (g == RK_COUNT - 1) ? mix_a : ring[(g + 1) % RK_COUNT];
		rc6_cell u_cell (
			.clk      (clk),
			.op       (cell_op),
			.init_val (INIT),
			.next1    (next1),
			.next2    (ring[(g + 2) % RK_COUNT]),
			.prev2    (ring[(g + RK_COUNT - 2) % RK_COUNT]),
			.data_q   (ring[g])
		);
	end

	rc6_key_mix u_key_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mix_ctl),
		.key_reg (key_reg_q),
		.s_head  (ring[0]),
		.mix_a_q (mix_a)
	);

	rc6_round_unit u_round (
		.mode   (mode_q),
		.a      (wa_q),
		.b      (wb_q),
		.c      (wc_q),
		.d      (wd_q),
		.k_even ((mode_q == MODE_ENC) ? ring[0] : ring[RK_COUNT - 2]),
		.k_odd  ((mode_q == MODE_ENC) ? ring[1] : ring[RK_COUNT - 1]),
		.a_nx   (ra),
		.b_nx   (rb),
		.c_nx   (rc),
		.d_nx   (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx        = state_q;
		cell_op         = CELL_HOLD;
		mix_ctl.op      = MIX_IDLE;
		mix_ctl.key_len = key_len_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nx = keys_ready_q ? ST_PRE : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cell_op    = CELL_LOAD;
				mix_ctl.op = MIX_LOAD;
				state_nx   = ST_MIXA;
			end
			ST_MIXA: begin
				mix_ctl.op = MIX_STEP_A;
				state_nx   = ST_MIXB;
			end
			ST_MIXB: begin
				cell_op    = CELL_SHIFT;
				mix_ctl.op = MIX_STEP_B;
				state_nx   = mix_last ? ST_PRE : ST_MIXA;
			end
			ST_PRE: begin
				cell_op  = (mode_q == MODE_ENC) ? CELL_FWD2 : CELL_BACK2;
				state_nx = ST_ROUND;
			end
			ST_ROUND: begin
				cell_op = (mode_q == MODE_ENC) ? CELL_FWD2 : CELL_BACK2;
				if (round_last) begin
					state_nx = ST_POST;
				end
			end
			ST_POST: begin
				cell_op  = (mode_q == MODE_ENC) ? CELL_FWD2 : CELL_BACK2;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_ready_q <= 1'b0;
			round_cnt_q  <= '0;
			mix_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			key_len_q    <= KEY_LEN_W'(16);
			for (int r = 0; r < KEY_REGS; r++) begin
				key_reg_q[r] <= '0;
			end
		end else begin
			if (state_q == ST_LOAD) begin
				mix_cnt_q <= '0;
			end else if (state_q == ST_MIXB) begin
				mix_cnt_q <= mix_last ? '0 : mix_cnt_q + MIX_CNT_W'(1);
				if (mix_last) begin
					keys_ready_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				round_cnt_q <= round_last ? '0 : round_cnt_q + ROUND_CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// any key write forces a fresh expansion
			if (cfg_xfer) begin
				if (cfg_index == CFG_KEY_LEN) begin
					key_len_q    <= cfg_data[KEY_LEN_W-1:0];
					keys_ready_q <= 1'b0;
				end else if (cfg_index == CFG_KEY_0_7 || cfg_index == CFG_KEY_8_15
					|| cfg_index == CFG_KEY_16_23 || cfg_index == CFG_KEY_24_31) begin
					key_reg_q[cfg_index[1:0]] <= cfg_data;
					keys_ready_q              <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode;
			wa_q   <= in_word_a;
			wb_q   <= in_word_b;
			wc_q   <= in_word_c;
			wd_q   <= in_word_d;
		end else if (state_q == ST_PRE) begin
			if (mode_q == MODE_ENC) begin
				wb_q <= wb_q + ring[0];
				wd_q <= wd_q + ring[1];
			end else begin
				wa_q <= wa_q - ring[RK_COUNT - 2];
				wc_q <= wc_q - ring[RK_COUNT - 1];
			end
		end else if (state_q == ST_ROUND) begin
			wa_q <= ra;
			wb_q <= rb;
			wc_q <= rc;
			wd_q <= rd;
		end else if (state_q == ST_POST) begin
			// ring has come round to the last two keys (encrypt) or the first two (decrypt) at the working end
			if (mode_q == MODE_ENC) begin
				wa_q <= wa_q + ring[0];
				wc_q <= wc_q + ring[1];
			end else begin
				wb_q <= wb_q - ring[RK_COUNT - 2];
				wd_q <= wd_q - ring[RK_COUNT - 1];
			end
		end
		if (out_load) begin
			out_word_a <= wa_q;
			out_word_b <= wb_q;
			out_word_c <= wc_q;
			out_word_d <= wd_q;
		end
	end

	a_round_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_cnt_q <= ROUND_CNT_W'(ROUNDS - 1))
		else $error("round counter out of range");

	a_mix_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		mix_cnt_q <= MIX_CNT_W'(MIX_STEPS - 1))
		else $error("mixing step counter out of range");

	a_pre_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_PRE) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_MIXB))
		else $error("whitening entered from a wrong state");

	a_keys_after_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIXB && mix_last && !cfg_xfer) |=> keys_ready_q)
		else $error("expansion finished without marking keys ready");

	a_round_from_pre: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_ROUND) |-> $past(state_q) == ST_PRE)
		else $error("rounds started without pre-whitening");

endmodule

`default_nettype wire
